// ===== rtl/fpcmp_pkg.sv =====
// Shared types and constants for the floating-point compare unit.
package fpcmp_pkg;
	typedef enum logic [1:0] {
		FMT_HALF   = 2'd0,
		FMT_SINGLE = 2'd1,
		FMT_DOUBLE = 2'd2,
		FMT_RSVD   = 2'd3
	} fmt_t;

	typedef enum logic [3:0] {
		OP_FALSE = 4'd0,
		OP_EQ    = 4'd1,
		OP_GT    = 4'd2,
		OP_GE    = 4'd3,
		OP_LT    = 4'd4,
		OP_LE    = 4'd5,
		OP_NE    = 4'd6,
		OP_ORD   = 4'd7,
		OP_UEQ   = 4'd8,
		OP_UGT   = 4'd9,
		OP_UGE   = 4'd10,
		OP_ULT   = 4'd11,
		OP_ULE   = 4'd12,
		OP_UNE   = 4'd13,
		OP_UNO   = 4'd14,
		OP_TRUE  = 4'd15
	} op_t;

	localparam logic [62:0] EXP_HALF   = 63'h7C00;
	localparam logic [62:0] EXP_SINGLE = 63'h7F80_0000;
	localparam logic [62:0] EXP_DOUBLE = 63'h7FF0_0000_0000_0000;

	typedef struct packed {
		logic uno;
		logic lt;
		logic eq;
	} order_t;

	function automatic logic apply_pred(input logic [3:0] op, input order_t o);
		logic gt;
		logic r;
		gt = !o.lt && !o.eq;
		case (op)
			OP_FALSE: r = 1'b0;
			OP_EQ:    r = !o.uno && o.eq;
			OP_GT:    r = !o.uno && gt;
			OP_GE:    r = !o.uno && (gt || o.eq);
			OP_LT:    r = !o.uno && o.lt;
			OP_LE:    r = !o.uno && (o.lt || o.eq);
			OP_NE:    r = !o.uno && !o.eq;
			OP_ORD:   r = !o.uno;
			OP_UEQ:   r = o.uno || o.eq;
			OP_UGT:   r = o.uno || gt;
			OP_UGE:   r = o.uno || gt || o.eq;
			OP_ULT:   r = o.uno || o.lt;
			OP_ULE:   r = o.uno || o.lt || o.eq;
			OP_UNE:   r = o.uno || !o.eq;
			OP_UNO:   r = o.uno;
			default:  r = 1'b1;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/fpcmp_core.sv =====
// Three-stage compare datapath: unpack, magnitude compare, predicate.
module fpcmp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_valid,
	input  fpcmp_pkg::fmt_t      fmt,
	input  logic [3:0]           operation,
	input  logic [63:0]          lhs_bits,
	input  logic [63:0]          rhs_bits,
	output logic                 valid_s3,
	output logic                 holds_s3
);
	import fpcmp_pkg::*;

	logic [62:0] ma, mb, emask;
	logic        sa, sb;

	always_comb begin
		case (fmt)
			FMT_HALF: begin
				ma = {48'd0, lhs_bits[14:0]};
				mb = {48'd0, rhs_bits[14:0]};
				sa = lhs_bits[15];
				sb = rhs_bits[15];
				emask = EXP_HALF;
			end
			FMT_SINGLE: begin
				ma = {32'd0, lhs_bits[30:0]};
				mb = {32'd0, rhs_bits[30:0]};
				sa = lhs_bits[31];
				sb = rhs_bits[31];
				emask = EXP_SINGLE;
			end
			default: begin
				ma = lhs_bits[62:0];
				mb = rhs_bits[62:0];
				sa = lhs_bits[63];
				sb = rhs_bits[63];
				emask = EXP_DOUBLE;
			end
		endcase
	end

	logic [62:0] ma_s1, mb_s1;
	logic        sa_s1, sb_s1, nana_s1, nanb_s1;
	logic [3:0]  op_s1;
	logic        valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ma_s1   <= ma;
			mb_s1   <= mb;
			sa_s1   <= sa;
			sb_s1   <= sb;
			nana_s1 <= ma > emask;
			nanb_s1 <= mb > emask;
			op_s1   <= operation;
		end
	end

	order_t ord;

	always_comb begin
		ord.uno = nana_s1 || nanb_s1;
		ord.lt  = 1'b0;
		ord.eq  = 1'b0;
		if (!ord.uno) begin
			if (ma_s1 == 63'd0 && mb_s1 == 63'd0) begin
				ord.eq = 1'b1;
			end else if (sa_s1 != sb_s1) begin
				ord.lt = sa_s1;
			end else if (ma_s1 == mb_s1) begin
				ord.eq = 1'b1;
			end else if (!sa_s1) begin
				ord.lt = ma_s1 < mb_s1;
			end else begin
				ord.lt = ma_s1 > mb_s1;
			end
		end
	end

	order_t     ord_s2;
	logic [3:0] op_s2;
	logic       valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ord_s2   <= ord;
			op_s2    <= op_s1;
			holds_s3 <= apply_pred(op_s2, ord_s2);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ord_s2.uno |-> !(ord_s2.lt && ord_s2.eq))
		else $error("lt and eq both set");
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 == $past(valid_s1))
		else $error("valid lost in stage 2");
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(valid_s3) && $stable(holds_s3))
		else $error("stage 3 moved while stalled");
endmodule

// ===== rtl/fp_compare_predicates_unit.sv =====
// The result passes through three register stages (unpack, compare, predicate) before out_valid rises.
// Throughput: one compare per cycle while the output is not stalled.
// A stall on the output freezes all stages together.
// Reset: asynchronous, active low; clears valid bits and sets format to double.
// Top level of the IEEE 754 compare unit with sixteen predicates.
module fp_compare_predicates_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  format,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  operation,
	input  logic [63:0] lhs_bits,
	input  logic [63:0] rhs_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        holds
);
	import fpcmp_pkg::*;

	fmt_t format_q;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid || out_ready;
	assign in_ready  = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_DOUBLE;
		end else if (cfg_valid && cfg_ready) begin
			format_q <= fmt_t'(format);
		end
	end

	fpcmp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (in_valid),
		.fmt       (format_q),
		.operation (operation),
		.lhs_bits  (lhs_bits),
		.rhs_bits  (rhs_bits),
		.valid_s3  (out_valid),
		.holds_s3  (holds)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(holds))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("ready mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> format_q == fmt_t'($past(format)))
		else $error("format write lost");
endmodule
